// ----- design/window_impulse_detector_unit_assert.svh -----
// Assertion macros for the window impulse detector.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef WINDOW_IMPULSE_DETECTOR_UNIT_ASSERT_SVH
`define WINDOW_IMPULSE_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define WID_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("window impulse detector: check failed");

// next-cycle implication
`define WID_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("window impulse detector: check failed");

`endif

// ----- design/wid_pkg.sv -----
// Shared types and constants of the window impulse detector.
// No dependencies.
package wid_pkg;

  localparam int SAMPLE_W = 16;
  localparam int THRESH_W = 8;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd51;

  // tuser kind codes
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // sequencer to lane strobes
  typedef struct packed {
    logic wr_en;     // write the sample at the write pointer
    logic fill_wr;   // latch the sample as value of the unfilled slots
    logic rd_en;     // walk read
    logic rd_first;  // first slot of the walk
    logic rd_fill;   // slot lies beyond the fill count
    logic mul_en;    // scale sum and extremes
    logic res_load;  // result goes to the output word
  } lane_ctrl_t;

endpackage

// ----- design/wid_lane.sv -----
// One axis lane: window memory, sum/min/max walk and band check.
// Depends on wid_pkg.
module wid_lane import wid_pkg::*; #(
  parameter int Depth = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lane_ctrl_t                 ctrl_i,
  input  logic [$clog2(Depth)-1:0]   wr_addr_i,
  input  logic [$clog2(Depth)-1:0]   rd_addr_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [THRESH_W-1:0]        thresh_i,
  output logic                       flag_o
);

  localparam int SW    = SAMPLE_W + $clog2(Depth);
  localparam int PW    = SW + 10;
  localparam int Scale = 256 * Depth;

  logic signed [SAMPLE_W-1:0] mem_q [Depth];
  logic signed [SAMPLE_W-1:0] rdata_q, fill_val_q, value;
  logic                       vld_q, first_q, sel_q;
  logic signed [SW-1:0]       sum_q;
  logic signed [SAMPLE_W-1:0] min_q, max_q;
  logic signed [PW-1:0]       lo_q, hi_q, smin_q, smax_q;
  logic signed [9:0]          fac_lo, fac_hi;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= sample_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      first_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      vld_q   <= ctrl_i.rd_en;
      first_q <= ctrl_i.rd_first;
      sel_q   <= ctrl_i.rd_fill;
    end
  end

  // slots past the fill count all hold the newest sample
  assign value = sel_q ? fill_val_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fill_wr) begin
      fill_val_q <= sample_i;
    end
    if (vld_q) begin
      if (first_q) begin
        sum_q <= SW'(value);
        min_q <= value;
        max_q <= value;
      end else begin
        sum_q <= sum_q + SW'(value);
        if (value < min_q) min_q <= value;
        if (value > max_q) max_q <= value;
      end
    end
    if (ctrl_i.mul_en) begin
      lo_q   <= PW'(sum_q) * PW'(fac_lo);
      hi_q   <= PW'(sum_q) * PW'(fac_hi);
      smin_q <= PW'(min_q) * PW'(Scale);
      smax_q <= PW'(max_q) * PW'(Scale);
    end
  end

  assign fac_lo = 10'sd256 - $signed({2'b00, thresh_i});
  assign fac_hi = 10'sd256 + $signed({2'b00, thresh_i});

  // out of band iff the extremes leave the band
  assign flag_o = (smin_q < lo_q) || (smax_q > hi_q);

endmodule

// ----- design/wid_ctrl.sv -----
// Sequencer: write pointer, fill count and the window walk.
// Depends on wid_pkg.
module wid_ctrl import wid_pkg::*; #(
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_clear_i,
  input  logic                     out_free_i,
  output logic                     in_ready_o,
  output lane_ctrl_t               ctrl_o,
  output logic [$clog2(Depth)-1:0] wr_addr_o,
  output logic [$clog2(Depth)-1:0] rd_addr_o
);

  localparam int IW = $clog2(Depth);
  localparam int FW = $clog2(Depth + 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StWalk  = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] cnt_q, wp_q;
  logic [FW-1:0] fill_q;
  logic          accept, full, last;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (fill_q == FW'(Depth));
  assign last       = (cnt_q == IW'(Depth - 1));

  assign wr_addr_o = wp_q;
  assign rd_addr_o = cnt_q;

  always_comb begin
    ctrl_o.wr_en    = accept && !in_clear_i;
    ctrl_o.fill_wr  = accept && !in_clear_i && !full;
    ctrl_o.rd_en    = (state_q == StWalk);
    ctrl_o.rd_first = (cnt_q == '0);
    ctrl_o.rd_fill  = (IW+1)'(cnt_q) >= (IW+1)'(fill_q);
    ctrl_o.mul_en   = (state_q == StMul);
    ctrl_o.res_load = (state_q == StDone) && out_free_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept && !in_clear_i) state_d = StWalk;
      StWalk:  if (last) state_d = StDrain;
      StDrain: state_d = StMul;
      StMul:   state_d = StDone;
      StDone:  if (out_free_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      wp_q    <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
        if (in_clear_i) begin
          wp_q   <= '0;
          fill_q <= '0;
        end else begin
          wp_q <= (wp_q == IW'(Depth - 1)) ? '0 : wp_q + 1'b1;
          if (!full) fill_q <= fill_q + 1'b1;
        end
      end else if (state_q == StWalk) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

endmodule

// ----- design/window_impulse_detector_unit.sv -----
// A sample word runs through the walk, drain, multiply and done states; the done state
// waits for the output to be free. No new sample word is taken until the result is loaded,
// and the walk over the window memories reads one slot per cycle; a clear word gives no result.
// Reset: threshold 51, window empty via the fill count; no clearing pass.
// Top level: config register, three axis lanes, merge and output word.
// Depends on wid_pkg, wid_ctrl, wid_lane and the assertion macro header.
`include "window_impulse_detector_unit_assert.svh"

module window_impulse_detector_unit import wid_pkg::*; #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [THRESH_W-1:0] cfg_wdata_i,     // threshold_q8
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [47:0]         s_axis_tdata_i,  // accel_x, accel_y, accel_z
  input  logic                s_axis_tuser_i,  // kind
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [7:0]          m_axis_tdata_o   // twist, zero fill
);

  localparam int IW = $clog2(WINDOW_DEPTH);

  logic [THRESH_W-1:0] thr_q;
  lane_ctrl_t          ctrl;
  logic [IW-1:0]       wr_addr, rd_addr;
  logic [2:0]          lane_flag;
  logic                out_free, in_clear;
  logic                m_valid_q, twist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign in_clear = (s_axis_tuser_i == KIND_CLEAR);
  assign out_free = !m_valid_q || m_axis_tready_i;

  wid_ctrl #(.Depth(WINDOW_DEPTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_clear_i (in_clear),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready_o),
    .ctrl_o     (ctrl),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr)
  );

  for (genvar a = 0; a < 3; a++) begin : g_lane
    wid_lane #(.Depth(WINDOW_DEPTH)) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .wr_addr_i (wr_addr),
      .rd_addr_i (rd_addr),
      .sample_i  ($signed(s_axis_tdata_i[a*SAMPLE_W +: SAMPLE_W])),
      .thresh_i  (thr_q),
      .flag_o    (lane_flag[a])
    );
  end

  // merge: any axis out of band
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.res_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.res_load) begin
      twist_q <= |lane_flag;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'b0, twist_q};

  `WID_ASSERT_IMP(a_load_free, ctrl.res_load, !m_valid_q || m_axis_tready_i)
  `WID_ASSERT_NXT(a_clear_idle, s_axis_tvalid_i && s_axis_tready_o && in_clear, s_axis_tready_o)
  `WID_ASSERT_NXT(a_sample_busy, s_axis_tvalid_i && s_axis_tready_o && !in_clear, !s_axis_tready_o)

endmodule
